@@ design/arm64_pc_relative_relocator_unit_assert.svh @@
`ifndef ARM64_PC_RELATIVE_RELOCATOR_UNIT_ASSERT_SVH
`define ARM64_PC_RELATIVE_RELOCATOR_UNIT_ASSERT_SVH
// Assertion helpers for the relocator modules; only the emitter includes them.
`define APR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define APR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

@@ design/apr_pkg.sv @@
`timescale 1ns / 1ps
package apr_pkg;

  localparam int unsigned PrologueWords = 4;
  localparam logic [31:0] NopWord = 32'hD503201F;

  typedef enum logic [4:0] {
    K_B, K_BC, K_BL, K_ADR, K_ADRP, K_LDR32, K_LDR64, K_LDRSW, K_PRFM,
    K_S32, K_S64, K_S128, K_CBZ, K_CBNZ, K_TBZ, K_TBNZ, K_OTHER
  } kind_e;

  typedef enum logic [2:0] {
    REG_ORIGIN = 3'd0, REG_RELOC = 3'd1, REG_LENGTH = 3'd2,
    REG_SAVED0 = 3'd3, REG_SAVED1 = 3'd4, REG_SAVED2 = 3'd5, REG_SAVED3 = 3'd6
  } reg_e;

  // Decoded item handed from the decode stage to the address stage.
  typedef struct packed {
    logic        jump_back;
    kind_e       kind;
    logic [31:0] word;
    logic [63:0] target;
    logic [5:0]  base;
  } dec_t;

  // Finished item handed to the emitter.
  typedef struct packed {
    logic        err;
    logic [3:0]  count;
    logic [31:0] word;
    kind_e       kind;
    logic        jump_back;
    logic [63:0] addr;
    logic [5:0]  base;
  } job_t;

  function automatic kind_e classify(input logic [31:0] w);
    kind_e k;
    k = K_OTHER;
    if ((w & 32'hFC000000) == 32'h14000000) k = K_B;
    else if ((w & 32'hFF000010) == 32'h54000000) k = K_BC;
    else if ((w & 32'hFC000000) == 32'h94000000) k = K_BL;
    else if ((w & 32'h9F000000) == 32'h10000000) k = K_ADR;
    else if ((w & 32'h9F000000) == 32'h90000000) k = K_ADRP;
    else if (w[31:24] == 8'h18) k = K_LDR32;
    else if (w[31:24] == 8'h58) k = K_LDR64;
    else if (w[31:24] == 8'h98) k = K_LDRSW;
    else if (w[31:24] == 8'hD8) k = K_PRFM;
    else if (w[31:24] == 8'h1C) k = K_S32;
    else if (w[31:24] == 8'h5C) k = K_S64;
    else if (w[31:24] == 8'h9C) k = K_S128;
    else if (w[30:24] == 7'h34) k = K_CBZ;
    else if (w[30:24] == 7'h35) k = K_CBNZ;
    else if (w[30:24] == 7'h36) k = K_TBZ;
    else if (w[30:24] == 7'h37) k = K_TBNZ;
    return k;
  endfunction

  function automatic logic [3:0] kind_words(input kind_e k);
    logic [3:0] n;
    case (k)
      K_BC, K_PRFM, K_S32, K_S64, K_S128: n = 4'd8;
      K_ADR, K_ADRP: n = 4'd4;
      K_OTHER: n = 4'd2;
      default: n = 4'd6;
    endcase
    return n;
  endfunction

endpackage

@@ design/apr_decode.sv @@
`timescale 1ns / 1ps
// Stage 1: picks the word, classifies it, forms the raw target and the buffer base.
module apr_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0]          idx_i,
  input  logic [2:0]          len_i,
  input  logic [63:0]         origin_i,
  input  logic [3:0][31:0]    saved_i,
  output logic                valid_o,
  output apr_pkg::dec_t       dec_o
);
  logic          valid_q, valid_d;
  apr_pkg::dec_t dec_q, dec_d;
  apr_pkg::kind_e k;
  logic [31:0]   w;
  logic [63:0]   pc;
  logic [63:0]   disp;
  logic [5:0]    base;
  logic [3:0]    cnt0, cnt1, cnt2;

  always_comb begin
    w    = saved_i[idx_i[1:0]];
    k    = apr_pkg::classify(w);
    pc   = origin_i + {59'd0, idx_i, 2'b00};
    cnt0 = apr_pkg::kind_words(apr_pkg::classify(saved_i[0]));
    cnt1 = apr_pkg::kind_words(apr_pkg::classify(saved_i[1]));
    cnt2 = apr_pkg::kind_words(apr_pkg::classify(saved_i[2]));
    case (idx_i)
      3'd0: base = 6'd0;
      3'd1: base = {2'd0, cnt0};
      3'd2: base = {2'd0, cnt0} + {2'd0, cnt1};
      3'd3: base = {2'd0, cnt0} + {2'd0, cnt1} + {2'd0, cnt2};
      default: base = {2'd0, cnt0} + {2'd0, cnt1} + {2'd0, cnt2}
                      + {2'd0, apr_pkg::kind_words(apr_pkg::classify(saved_i[3]))};
    endcase
    case (k)
      apr_pkg::K_B, apr_pkg::K_BL: disp = {{36{w[25]}}, w[25:0], 2'b00};
      apr_pkg::K_ADR: disp = {{43{w[23]}}, w[23:5], w[30:29]};
      apr_pkg::K_ADRP: disp = {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
      apr_pkg::K_TBZ, apr_pkg::K_TBNZ: disp = {{48{w[18]}}, w[18:5], 2'b00};
      apr_pkg::K_OTHER: disp = 64'd0;
      default: disp = {{43{w[23]}}, w[23:5], 2'b00};
    endcase
    valid_d         = valid_i && (idx_i <= len_i);
    dec_d.jump_back = (idx_i == len_i);
    dec_d.kind      = k;
    dec_d.word      = w;
    dec_d.target    = dec_d.jump_back ? origin_i + {59'd0, len_i, 2'b00} : pc + disp;
    dec_d.base      = base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
endmodule

@@ design/apr_map.sv @@
`timescale 1ns / 1ps
// Stage 2: prologue range check, relocation of inner targets, refusal decision.
module apr_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  apr_pkg::dec_t    dec_i,
  input  logic [2:0]       len_i,
  input  logic [63:0]      origin_i,
  input  logic [63:0]      reloc_i,
  input  logic [3:0][31:0] saved_i,
  output logic             valid_o,
  output apr_pkg::job_t    job_o
);
  logic          valid_q;
  apr_pkg::job_t job_q, job_d;
  logic [63:0]   a, end_a, diff, mapped;
  logic          in_range;
  logic [5:0]    off;
  logic [3:0]    c0, c1, c2;
  apr_pkg::kind_e k;

  always_comb begin
    k      = dec_i.kind;
    // The jump back carries a plain address, whatever the word at its index decodes to.
    a      = (k == apr_pkg::K_ADRP && !dec_i.jump_back) ? {dec_i.target[63:12], 12'd0}
                                                         : dec_i.target;
    end_a  = origin_i + {59'd0, len_i, 2'b00};
    in_range = (a >= origin_i) && (a < end_a);
    diff   = a - origin_i;
    c0 = apr_pkg::kind_words(apr_pkg::classify(saved_i[0]));
    c1 = apr_pkg::kind_words(apr_pkg::classify(saved_i[1]));
    c2 = apr_pkg::kind_words(apr_pkg::classify(saved_i[2]));
    case (diff[3:2])
      2'd0: off = 6'd0;
      2'd1: off = {2'd0, c0};
      2'd2: off = {2'd0, c0} + {2'd0, c1};
      default: off = {2'd0, c0} + {2'd0, c1} + {2'd0, c2};
    endcase
    mapped = reloc_i + {56'd0, off, 2'b00};
    job_d.jump_back = dec_i.jump_back;
    job_d.kind      = k;
    job_d.word      = dec_i.word;
    job_d.base      = dec_i.base;
    job_d.err       = 1'b0;
    job_d.addr      = a;
    if (dec_i.jump_back) begin
      job_d.count = 4'd4;
    end else begin
      job_d.count = apr_pkg::kind_words(k);
      case (k)
        apr_pkg::K_ADR, apr_pkg::K_OTHER: job_d.addr = a;
        apr_pkg::K_ADRP: job_d.err = in_range;
        apr_pkg::K_LDR32, apr_pkg::K_LDR64, apr_pkg::K_LDRSW,
        apr_pkg::K_S32, apr_pkg::K_S64, apr_pkg::K_S128: job_d.err = in_range;
        default: if (in_range) job_d.addr = mapped;
      endcase
    end
    if (job_d.err) job_d.count = 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q <= job_d;
    end
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;
endmodule

@@ design/apr_emit.sv @@
`timescale 1ns / 1ps
// Stage 3: sequences the replacement words of one job into a registered output.
module apr_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  apr_pkg::job_t job_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [31:0]   word_o,
  output logic [5:0]    offset_o,
  output logic          last_o,
  output logic          status_o
);
  logic [2:0]  pos_q, pos_d;
  logic        ov_q, ov_d;
  logic [31:0] word_q, word_d;
  logic [5:0]  off_q, off_d;
  logic        last_q, last_d, st_q, st_d;
  logic        out_free, fire, last_now;
  logic [31:0] w, lo, hi, rt;
  apr_pkg::kind_e k;

  always_comb begin
    k  = job_i.kind;
    w  = job_i.word;
    lo = job_i.addr[31:0];
    hi = job_i.addr[63:32];
    rt = {27'd0, w[4:0]};
    word_d = apr_pkg::NopWord;
    if (job_i.err) begin
      word_d = 32'd0;
    end else if (job_i.jump_back) begin
      case (pos_q)
        3'd0: word_d = 32'h58000051;
        3'd1: word_d = 32'hD65F0220;
        3'd2: word_d = lo;
        default: word_d = hi;
      endcase
    end else begin
      case (k)
        apr_pkg::K_B, apr_pkg::K_BL, apr_pkg::K_BC: begin
          case (pos_q - ((k == apr_pkg::K_BC) ? 3'd2 : 3'd0))
            3'd0: word_d = 32'h58000051;
            3'd1: word_d = 32'h14000003;
            3'd2: word_d = lo;
            3'd3: word_d = hi;
            3'd4: word_d = (k == apr_pkg::K_BL) ? 32'hD63F0220 : 32'hD61F0220;
            3'd5: word_d = apr_pkg::NopWord;
            3'd6: word_d = (w & 32'hFF00001F) | 32'h40;
            default: word_d = 32'h14000006;
          endcase
        end
        apr_pkg::K_ADR, apr_pkg::K_ADRP: begin
          case (pos_q)
            3'd0: word_d = 32'h58000040 | rt;
            3'd1: word_d = 32'h14000003;
            3'd2: word_d = lo;
            default: word_d = hi;
          endcase
        end
        apr_pkg::K_LDR32, apr_pkg::K_LDR64, apr_pkg::K_LDRSW: begin
          case (pos_q)
            3'd0: word_d = 32'h58000060 | rt;
            3'd1: word_d = ((k == apr_pkg::K_LDR32) ? 32'hB9400000 :
                            (k == apr_pkg::K_LDR64) ? 32'hF9400000 : 32'hB9800000)
                           | rt | (rt << 5);
            3'd2: word_d = 32'h14000004;
            3'd3: word_d = apr_pkg::NopWord;
            3'd4: word_d = lo;
            default: word_d = hi;
          endcase
        end
        apr_pkg::K_PRFM, apr_pkg::K_S32, apr_pkg::K_S64, apr_pkg::K_S128: begin
          case (pos_q)
            3'd0: word_d = 32'hA93F47F0;
            3'd1: word_d = 32'h58000091;
            3'd2: word_d = ((k == apr_pkg::K_PRFM) ? 32'hF9800220 :
                            (k == apr_pkg::K_S32) ? 32'hBD400220 :
                            (k == apr_pkg::K_S64) ? 32'hFD400220 : 32'h3DC00220) | rt;
            3'd3: word_d = 32'hF85F83F1;
            3'd4: word_d = 32'h14000004;
            3'd5: word_d = apr_pkg::NopWord;
            3'd6: word_d = lo;
            default: word_d = hi;
          endcase
        end
        apr_pkg::K_CBZ, apr_pkg::K_CBNZ, apr_pkg::K_TBZ, apr_pkg::K_TBNZ: begin
          case (pos_q)
            3'd0: word_d = (k == apr_pkg::K_CBZ || k == apr_pkg::K_CBNZ)
                           ? ((w & 32'hFF00001F) | 32'h40) : ((w & 32'hFFF8001F) | 32'h40);
            3'd1: word_d = 32'h14000005;
            3'd2: word_d = 32'h58000051;
            3'd3: word_d = 32'hD61F0220;
            3'd4: word_d = lo;
            default: word_d = hi;
          endcase
        end
        default: word_d = (pos_q == 3'd0) ? w : apr_pkg::NopWord;
      endcase
    end
  end

  // B.cond puts its two guard words first; they are generated at rotated positions.
  logic [2:0] sel_pos;
  assign sel_pos = pos_q;

  always_comb begin
    out_free = !ov_q || ready_i;
    fire     = valid_i && out_free;
    last_now = ({1'b0, sel_pos} + 4'd1 == job_i.count);
    ready_o  = fire && last_now;
    pos_d    = fire ? (last_now ? 3'd0 : pos_q + 3'd1) : pos_q;
    ov_d     = fire ? 1'b1 : (ready_i ? 1'b0 : ov_q);
    off_d    = job_i.base + {3'd0, pos_q};
    last_d   = last_now;
    st_d     = job_i.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
      ov_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ov_q  <= ov_d;
    end
  end

  logic [31:0] word_sel;
  always_comb begin
    word_sel = word_d;
    if (!job_i.err && !job_i.jump_back && k == apr_pkg::K_BC) begin
      if (pos_q == 3'd0) word_sel = (w & 32'hFF00001F) | 32'h40;
      else if (pos_q == 3'd1) word_sel = 32'h14000006;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      word_q <= word_sel;
      off_q  <= off_d;
      last_q <= last_d;
      st_q   <= st_d;
    end
  end

  assign valid_o  = ov_q;
  assign word_o   = word_q;
  assign offset_o = off_q;
  assign last_o   = last_q;
  assign status_o = st_q;

  `include "arm64_pc_relative_relocator_unit_assert.svh"
  `APR_ASSERT(a_pos_bound, valid_i |-> ({1'b0, pos_q} < job_i.count), "position past job")
  `APR_ASSERT(a_err_single, (valid_i && job_i.err) |-> (pos_q == 3'd0), "refusal spans words")
  `APR_ASSERT(a_hold, (ov_q && !ready_i) |=> $stable(word_q) && ov_q, "stalled output changed")
endmodule

@@ design/arm64_pc_relative_relocator_unit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tdata[2:0] inst_index
// m_axis    out  tdata[37:0] out_word, word_offset; tuser status; tlast last_word
// cfg       in   cfg_index_i register index, cfg_data_i value
// An item passes the decode and map stages and then emits 1 to 8 words, one per cycle
// while m_axis is not stalled; the emitter takes its next item after the last word.
// Reset clears all valid bits and the registers to their reset values.
// A stall on m_axis holds each full stage whose successor is full; nothing is lost or repeated.
module arm64_pc_relative_relocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] inst_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_word, [37:32] word_offset
  output logic        m_axis_tuser,   // status
  output logic        m_axis_tlast,   // last_word
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  logic [63:0]      origin_q, reloc_q;
  logic [2:0]       len_q, len_eff;
  logic [3:0][31:0] saved_q;
  logic             d_valid, m_valid, e_ready, en1, en2;
  apr_pkg::dec_t    dec;
  apr_pkg::job_t    job;
  logic [31:0]      word;
  logic [5:0]       off;

  assign cfg_ready_o = 1'b1;
  assign len_eff = (len_q > 3'(apr_pkg::PrologueWords)) ? 3'(apr_pkg::PrologueWords) : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      reloc_q  <= '0;
      len_q    <= 3'd4;
      saved_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        apr_pkg::REG_ORIGIN: origin_q <= cfg_data_i;
        apr_pkg::REG_RELOC:  reloc_q  <= cfg_data_i;
        apr_pkg::REG_LENGTH: len_q    <= cfg_data_i[2:0];
        apr_pkg::REG_SAVED0: saved_q[0] <= cfg_data_i[31:0];
        apr_pkg::REG_SAVED1: saved_q[1] <= cfg_data_i[31:0];
        apr_pkg::REG_SAVED2: saved_q[2] <= cfg_data_i[31:0];
        apr_pkg::REG_SAVED3: saved_q[3] <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign en2 = !m_valid || e_ready;
  assign en1 = !d_valid || en2;
  assign s_axis_tready = en1;

  apr_decode u_dec (
    .clk_i, .rst_ni, .en_i(en1), .valid_i(s_axis_tvalid), .idx_i(s_axis_tdata[2:0]),
    .len_i(len_eff), .origin_i(origin_q), .saved_i(saved_q),
    .valid_o(d_valid), .dec_o(dec)
  );

  apr_map u_map (
    .clk_i, .rst_ni, .en_i(en2), .valid_i(d_valid), .dec_i(dec), .len_i(len_eff),
    .origin_i(origin_q), .reloc_i(reloc_q), .saved_i(saved_q),
    .valid_o(m_valid), .job_o(job)
  );

  apr_emit u_emit (
    .clk_i, .rst_ni, .valid_i(m_valid), .job_i(job), .ready_o(e_ready),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .word_o(word), .offset_o(off),
    .last_o(m_axis_tlast), .status_o(m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, off, word};
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import apr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 16;
  localparam logic [31:0] Nop = 32'hD503201F;

  localparam logic [31:0] KindMask [17] = '{
    32'hFC000000, 32'hFF000010, 32'hFC000000, 32'h9F000000, 32'h9F000000, 32'hFF000000,
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'h7F000000, 32'h7F000000, 32'h7F000000, 32'h7F000000, 32'h00000000};
  localparam logic [31:0] KindType [17] = '{
    32'h14000000, 32'h54000000, 32'h94000000, 32'h10000000, 32'h90000000, 32'h18000000,
    32'h58000000, 32'h98000000, 32'hD8000000, 32'h1C000000, 32'h5C000000, 32'h9C000000,
    32'h34000000, 32'h35000000, 32'h36000000, 32'h37000000, 32'h00000000};
  localparam int KindLen [17] = '{6, 8, 6, 4, 4, 6, 6, 6, 8, 8, 8, 8, 6, 6, 6, 6, 2};

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  offset;
    logic        last;
    logic        status;
  } emit_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_REFUSED} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_e        reg_idx;
    logic [63:0] data;
    logic [2:0]  idx;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  arm64_pc_relative_relocator_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow copy of the configuration registers.
  logic [63:0] shadow_origin;
  logic [63:0] reloc_addr;
  logic [2:0]  length_reg;
  logic [31:0] saved_words [4];

  emit_t       pending_words [$];
  row_t        dir_rows [$];
  int unsigned cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned words_seen;
  int unsigned refusals_seen;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $realtime, pending_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int kind_of(input logic [31:0] w);
    for (int k = 0; k < 17; k++) begin
      if ((w & KindMask[k]) == KindType[k]) return k;
    end
    return int'(K_OTHER);
  endfunction

  function automatic int eff_length();
    return (length_reg > 3'd4) ? 4 : int'(length_reg);
  endfunction

  function automatic int buffer_base(input int idx);
    int s;
    s = 0;
    for (int i = 0; i < idx && i < 4; i++) s += KindLen[kind_of(saved_words[i])];
    return s;
  endfunction

  function automatic bit in_prologue(input logic [63:0] a);
    logic [63:0] stop;
    stop = shadow_origin + 64'(eff_length() * 4);
    return (a >= shadow_origin) && (a < stop);
  endfunction

  function automatic logic [63:0] remap(input logic [63:0] a);
    if (!in_prologue(a)) return a;
    return reloc_addr + 64'(buffer_base(int'((a - shadow_origin) >> 2)) * 4);
  endfunction

  // Expands one accepted index into the words the relocation buffer should receive.
  function automatic void predict_words(input logic [2:0] idx);
    logic [31:0] buf_w [8];
    logic [31:0] w;
    logic [63:0] pc;
    logic [63:0] a;
    logic [4:0]  rt;
    int          n;
    int          base;
    int          len;
    kind_e       k;
    bit          refused;
    emit_t       e;
    len = eff_length();
    n = 0;
    refused = 1'b0;
    if (int'(idx) > len) return;
    base = buffer_base(idx);
    if (int'(idx) == len) begin
      a = shadow_origin + 64'(len * 4);
      buf_w[0] = 32'h58000051; buf_w[1] = 32'hD65F0220;
      buf_w[2] = a[31:0]; buf_w[3] = a[63:32];
      n = 4;
    end else begin
      w = saved_words[idx[1:0]];
      pc = shadow_origin + 64'(idx) * 4;
      rt = w[4:0];
      k = kind_e'(kind_of(w));
      case (k)
        K_B, K_BC, K_BL: begin
          if (k == K_BC) a = pc + {{43{w[23]}}, w[23:5], 2'b00};
          else a = pc + {{36{w[25]}}, w[25:0], 2'b00};
          a = remap(a);
          if (k == K_BC) begin
            buf_w[n++] = (w & 32'hFF00001F) | 32'h40;
            buf_w[n++] = 32'h14000006;
          end
          buf_w[n++] = 32'h58000051; buf_w[n++] = 32'h14000003;
          buf_w[n++] = a[31:0]; buf_w[n++] = a[63:32];
          buf_w[n++] = (k == K_BL) ? 32'hD63F0220 : 32'hD61F0220;
          buf_w[n++] = Nop;
        end
        K_ADR, K_ADRP: begin
          if (k == K_ADR) begin
            a = pc + {{43{w[23]}}, w[23:5], w[30:29]};
          end else begin
            a = (pc + {{31{w[23]}}, w[23:5], w[30:29], 12'h000}) & 64'hFFFFFFFFFFFFF000;
            refused = in_prologue(a);
          end
          buf_w[0] = 32'h58000040 | rt; buf_w[1] = 32'h14000003;
          buf_w[2] = a[31:0]; buf_w[3] = a[63:32];
          n = 4;
        end
        K_LDR32, K_LDR64, K_LDRSW, K_PRFM, K_S32, K_S64, K_S128: begin
          a = pc + {{43{w[23]}}, w[23:5], 2'b00};
          refused = in_prologue(a) && (k != K_PRFM);
          a = remap(a);
          if (k == K_LDR32 || k == K_LDR64 || k == K_LDRSW) begin
            buf_w[0] = 32'h58000060 | rt;
            buf_w[1] = ((k == K_LDR32) ? 32'hB9400000 : (k == K_LDR64) ? 32'hF9400000 :
                        32'hB9800000) | rt | (32'(rt) << 5);
            buf_w[2] = 32'h14000004; buf_w[3] = Nop;
            buf_w[4] = a[31:0]; buf_w[5] = a[63:32];
            n = 6;
          end else begin
            buf_w[0] = 32'hA93F47F0; buf_w[1] = 32'h58000091;
            buf_w[2] = ((k == K_PRFM) ? 32'hF9800220 : (k == K_S32) ? 32'hBD400220 :
                        (k == K_S64) ? 32'hFD400220 : 32'h3DC00220) | rt;
            buf_w[3] = 32'hF85F83F1; buf_w[4] = 32'h14000004; buf_w[5] = Nop;
            buf_w[6] = a[31:0]; buf_w[7] = a[63:32];
            n = 8;
          end
        end
        K_CBZ, K_CBNZ, K_TBZ, K_TBNZ: begin
          if (k == K_CBZ || k == K_CBNZ) begin
            a = pc + {{43{w[23]}}, w[23:5], 2'b00};
            buf_w[0] = (w & 32'hFF00001F) | 32'h40;
          end else begin
            a = pc + {{48{w[18]}}, w[18:5], 2'b00};
            buf_w[0] = (w & 32'hFFF8001F) | 32'h40;
          end
          a = remap(a);
          buf_w[1] = 32'h14000005; buf_w[2] = 32'h58000051; buf_w[3] = 32'hD61F0220;
          buf_w[4] = a[31:0]; buf_w[5] = a[63:32];
          n = 6;
        end
        default: begin
          buf_w[0] = w; buf_w[1] = Nop;
          n = 2;
        end
      endcase
    end
    if (refused) begin
      e = '{word: 32'h0, offset: 6'(base), last: 1'b1, status: 1'b1};
      pending_words.push_back(e);
      return;
    end
    for (int i = 0; i < n; i++) begin
      e = '{word: buf_w[i], offset: 6'(base + i), last: (i == n - 1), status: 1'b0};
      pending_words.push_back(e);
    end
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0) @(posedge clk_i);
    // An index past the length yields nothing, so allow the pipeline to empty.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(input reg_e r, input logic [63:0] d);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    case (r)
      REG_ORIGIN: shadow_origin = d;
      REG_RELOC:  reloc_addr = d;
      REG_LENGTH: length_reg = d[2:0];
      default:    saved_words[int'(r) - int'(REG_SAVED0)] = d[31:0];
    endcase
  endtask

  // Sends one index. The refused form carries its expected buffer offset instead of
  // asking the predictor.
  task automatic send_index(input logic [2:0] idx, input bit refused, input logic [5:0] off);
    int gap;
    bit ok;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, idx};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    items_sent++;
    if (refused) pending_words.push_back('{word: 32'h0, offset: off, last: 1'b1, status: 1'b1});
    else predict_words(idx);
  endtask

  function automatic void add_cfg(input reg_e r, input logic [63:0] d);
    dir_rows.push_back('{kind: ROW_CFG, reg_idx: r, data: d, idx: 3'd0});
  endfunction

  function automatic void add_item(input logic [2:0] idx);
    dir_rows.push_back('{kind: ROW_ITEM, reg_idx: REG_ORIGIN, data: 64'h0, idx: idx});
  endfunction

  function automatic void add_refused(input logic [2:0] idx, input logic [5:0] off);
    dir_rows.push_back('{kind: ROW_REFUSED, reg_idx: REG_ORIGIN, data: 64'(off), idx: idx});
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int k;
    int s;
    k = $urandom_range(0, 16);
    w = $urandom;
    if ($urandom_range(0, 9) < 8) w = (w & ~KindMask[k]) | KindType[k];
    // Short displacements land targets in or near the prologue.
    if ($urandom_range(0, 1) == 1) begin
      s = int'($urandom_range(0, 8)) - 3;
      case (kind_e'(k))
        K_B, K_BL: w[25:0] = 26'(s);
        K_TBZ, K_TBNZ: w[18:5] = 14'(s);
        K_ADR, K_ADRP: begin
          w[23:5] = 19'(s >>> 2);
          w[30:29] = 2'(s);
        end
        default: w[23:5] = 19'(s);
      endcase
    end
    return w;
  endfunction

  function automatic logic [63:0] random_addr();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {32'hFFFFFFFF, 32'hFFFFFFF0 + $urandom_range(0, 15)};
      2: return 64'($urandom_range(0, 255)) << 2;
      default: return {$urandom, $urandom} & 64'hFFFFFFFFFFFFF00C;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : rx_ready
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall = 0;
    end else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) < 3) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      end
    end
  end

  always @(negedge clk_i) begin
    emit_t got;
    emit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{word: m_axis_tdata[31:0], offset: m_axis_tdata[37:32], last: m_axis_tlast,
              status: m_axis_tuser};
      words_seen++;
      if (got.status) refusals_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h offset %0d", $realtime, got.word, got.offset);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got.word !== want.word) begin
          $display("%0t: out_word expected %h actual %h", $realtime, want.word, got.word);
          errors++;
        end
        if (got.offset !== want.offset) begin
          $display("%0t: word_offset expected %0d actual %0d", $realtime, want.offset,
                   got.offset);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_word expected %b actual %b", $realtime, want.last, got.last);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $realtime, want.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    items_sent = 0;
    words_seen = 0;
    refusals_seen = 0;
    quiet = 1'b0;
    shadow_origin = 64'h0;
    reloc_addr = 64'h0;
    length_reg = 3'd4;
    for (int i = 0; i < 4; i++) saved_words[i] = 32'h0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ORIGIN;
    cfg_data_i = 64'h0;

    // Reset values: four plain words, then the jump back, then indexes past the end.
    add_item(3'd0); add_item(3'd4); add_item(3'd5); add_item(3'd7);
    // Branches with targets inside the prologue.
    add_cfg(REG_ORIGIN, 64'h1000); add_cfg(REG_RELOC, 64'h8000);
    add_cfg(REG_SAVED0, 32'h14000001); add_cfg(REG_SAVED1, 32'h54000040);
    add_cfg(REG_SAVED2, 32'h97FFFFFF); add_cfg(REG_SAVED3, 32'h10000000);
    add_item(3'd0); add_item(3'd1); add_item(3'd2); add_item(3'd3); add_item(3'd4);
    // An ADRP page and two literal loads inside the prologue are refused.
    add_cfg(REG_SAVED0, 32'h90000000); add_cfg(REG_SAVED1, 32'h18000000);
    add_cfg(REG_SAVED2, 32'h58FFFFE5); add_cfg(REG_SAVED3, 32'h98000025);
    add_refused(3'd0, 6'd0); add_refused(3'd1, 6'd4); add_item(3'd2); add_item(3'd3);
    // Prefetch and SIMD literal loads, with a three-word prologue.
    add_cfg(REG_LENGTH, 64'd3);
    add_cfg(REG_SAVED0, 32'hD8000000); add_cfg(REG_SAVED1, 32'h1C7FFFE0);
    add_cfg(REG_SAVED2, 32'h5C000041); add_cfg(REG_SAVED3, 32'h9C800002);
    add_item(3'd0); add_item(3'd1); add_item(3'd2); add_item(3'd3);
    // Compare and test branches at the top of the address space, saturated length.
    add_cfg(REG_ORIGIN, 64'hFFFFFFFFFFFFFFF8); add_cfg(REG_RELOC, 64'hFFFFFFFFFFFFFFFF);
    add_cfg(REG_LENGTH, 64'd7);
    add_cfg(REG_SAVED0, 32'h34000021); add_cfg(REG_SAVED1, 32'hB5FFFFE2);
    add_cfg(REG_SAVED2, 32'h36000003); add_cfg(REG_SAVED3, 32'hB7FFFFE4);
    add_item(3'd0); add_item(3'd1); add_item(3'd2); add_item(3'd3); add_item(3'd4);
    // Empty prologue, then a single word one.
    add_cfg(REG_LENGTH, 64'd0); add_item(3'd0); add_item(3'd1);
    add_cfg(REG_LENGTH, 64'd1); add_item(3'd0); add_item(3'd1); add_item(3'd2);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          s_axis_tvalid <= 1'b0;
          wait_idle();
          write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
        end
        ROW_ITEM:    send_index(dir_rows[i].idx, 1'b0, 6'd0);
        default:     send_index(dir_rows[i].idx, 1'b1, dir_rows[i].data[5:0]);
      endcase
    end

    for (int phase = 0; phase < 10; phase++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      quiet = (phase % 4 == 3);
      write_reg(REG_ORIGIN, random_addr());
      write_reg(REG_RELOC, random_addr());
      write_reg(REG_LENGTH, 64'($urandom_range(0, 7)));
      write_reg(REG_SAVED0, 64'(random_word()));
      write_reg(REG_SAVED1, 64'(random_word()));
      write_reg(REG_SAVED2, 64'(random_word()));
      write_reg(REG_SAVED3, 64'(random_word()));
      for (int j = 0; j < 10; j++) begin
        if ($urandom_range(0, 9) < 9) begin
          send_index(3'($urandom_range(0, eff_length())), 1'b0, 6'd0);
        end else begin
          send_index(3'($urandom_range(0, 7)), 1'b0, 6'd0);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    $display("Relocated %0d indexes into %0d buffer words, %0d of them refusals.",
             items_sent, words_seen, refusals_seen);
    $display("Covered every instruction class, length 0 to 7, and wrapping addresses.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
